>>> rtl/core/acsi_pkg.sv
package acsi_pkg;

   // Parser configuration.
   localparam int ACSI_MAX_PARAMS = 4;
   localparam int PARAM_W         = 15;
   localparam logic [PARAM_W-1:0] PARAM_CAP = 15'h7fff;

   // Parser modes.
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESC    = 2'd1;
   localparam logic [1:0] MODE_CSI    = 2'd2;

   // Command codes.
   localparam logic [3:0] CMD_PUTC    = 4'd0;
   localparam logic [3:0] CMD_SETPOS  = 4'd1;
   localparam logic [3:0] CMD_MOVE    = 4'd2;
   localparam logic [3:0] CMD_CLRSCR  = 4'd3;
   localparam logic [3:0] CMD_CLREOS  = 4'd4;
   localparam logic [3:0] CMD_CLRLINE = 4'd5;
   localparam logic [3:0] CMD_CLREOL  = 4'd6;
   localparam logic [3:0] CMD_REVERSE = 4'd7;
   localparam logic [3:0] CMD_FG      = 4'd8;
   localparam logic [3:0] CMD_BG      = 4'd9;
   localparam logic [3:0] CMD_CURSOR  = 4'd10;

   // Byte codes the parser recognizes.
   localparam logic [7:0] CH_ESC    = 8'h1b;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_QMARK  = 8'h3f;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5a;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;

   // Final bytes with an action.
   localparam logic [7:0] FIN_CUP_H = 8'h48;
   localparam logic [7:0] FIN_CUP_F = 8'h66;
   localparam logic [7:0] FIN_CUU   = 8'h41;
   localparam logic [7:0] FIN_CUD   = 8'h42;
   localparam logic [7:0] FIN_CUF   = 8'h43;
   localparam logic [7:0] FIN_CUB   = 8'h44;
   localparam logic [7:0] FIN_ED    = 8'h4a;
   localparam logic [7:0] FIN_EL    = 8'h4b;
   localparam logic [7:0] FIN_SGR   = 8'h6d;
   localparam logic [7:0] FIN_SET   = 8'h68;
   localparam logic [7:0] FIN_RESET = 8'h6c;

   // Parameter values with a meaning.
   localparam logic [PARAM_W-1:0] PV_CURSOR  = 15'd25;
   localparam logic [PARAM_W-1:0] PV_ERASE_ALL = 15'd2;
   localparam logic [PARAM_W-1:0] PV_SGR_RESET = 15'd0;
   localparam logic [PARAM_W-1:0] PV_SGR_REVERSE = 15'd7;
   localparam logic [PARAM_W-1:0] PV_SGR_FG_DEFAULT = 15'd39;

   // Colors used by the SGR reset.
   localparam logic [15:0] COLOR_FG_DEFAULT = 16'd7;
   localparam logic [15:0] COLOR_BG_DEFAULT = 16'd0;

   // Configuration register indexes.
   localparam logic CSR_IDX_DISPLAY_EN = 1'b0;

   // Control from the sequencer to the parameter store.
   typedef struct packed {
      logic       clear;
      logic       acc;
      logic [3:0] digit;
   } acsi_store_ctl_type;

   // Maps an SGR foreground code to a palette index. Bit 4 is set when the
   // code names a color.
   function automatic logic [4:0] palette_of(input logic [PARAM_W-1:0] p);
      logic [4:0] r;
      case (p)
         15'd30: r = 5'h10;
         15'd31: r = 5'h14;
         15'd32: r = 5'h12;
         15'd33: r = 5'h1e;
         15'd34: r = 5'h11;
         15'd35: r = 5'h15;
         15'd36: r = 5'h13;
         15'd37: r = 5'h17;
         15'd90: r = 5'h18;
         15'd91: r = 5'h1c;
         15'd92: r = 5'h1a;
         15'd93: r = 5'h1e;
         15'd94: r = 5'h19;
         15'd95: r = 5'h1d;
         15'd96: r = 5'h1b;
         15'd97: r = 5'h1f;
         default: r = 5'h00;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/acsi_param_store.sv
module acsi_param_store
   import acsi_pkg::*;
#(
   parameter int MAX_PARAMS = ACSI_MAX_PARAMS,
   localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  acsi_store_ctl_type        ctl,
   input  logic [IDX_W-1:0]          idx,
   output logic [PARAM_W-1:0]        rd_value,
   output logic [PARAM_W-1:0]        p0,
   output logic [PARAM_W-1:0]        p1
);

   logic [PARAM_W-1:0]    val_ff [MAX_PARAMS];
   logic [MAX_PARAMS-1:0] present_ff;
   logic [PARAM_W+3:0]    acc_sum;
   logic [PARAM_W-1:0]    acc_in;

   // Single read port shared by digit accumulation and the SGR walk.
   assign rd_value = present_ff[idx] ? val_ff[idx] : '0;
   assign p0       = present_ff[0] ? val_ff[0] : '0;

   generate
      if (MAX_PARAMS > 1) begin : g_p1
         assign p1 = present_ff[1] ? val_ff[1] : '0;
      end else begin : g_no_p1
         assign p1 = '0;
      end
   endgenerate

   // Multiply-by-ten and add unit with saturation.
   always_comb begin
      acc_sum = {1'b0, rd_value, 3'b000} + {3'b000, rd_value, 1'b0} +
                {{PARAM_W{1'b0}}, ctl.digit};
      if (acc_sum > {4'b0000, PARAM_CAP}) begin
         acc_in = PARAM_CAP;
      end else begin
         acc_in = acc_sum[PARAM_W-1:0];
      end
   end

   // Presence bits: an absent parameter reads as zero.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         present_ff <= '0;
      end else if (ctl.acc) begin
         present_ff[idx] <= 1'b1;
      end
   end

   // Parameter values.
   always_ff @(posedge clock) begin
      if (ctl.acc && !ctl.clear) begin
         val_ff[idx] <= acc_in;
      end
   end

endmodule

>>> rtl/core/acsi_sequencer.sv
module acsi_sequencer
   import acsi_pkg::*;
#(
   parameter int MAX_PARAMS = ACSI_MAX_PARAMS,
   localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 display_en,
   // Incoming byte transaction
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_byte,
   input  logic [7:0]           in_terminal,
   input  logic                 in_first,
   // Parameter store
   output acsi_store_ctl_type   store_ctl,
   output logic [IDX_W-1:0]     store_idx,
   input  logic [PARAM_W-1:0]   store_rd,
   input  logic [PARAM_W-1:0]   p0,
   input  logic [PARAM_W-1:0]   p1,
   // Command output register
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [3:0]           out_cmd,
   output logic [7:0]           out_terminal,
   output logic [15:0]          out_a,
   output logic [15:0]          out_b,
   output logic                 out_last
);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PARAMS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_ESC2   = 3'd2;
   localparam logic [2:0] ST_SGR    = 3'd3;
   localparam logic [2:0] ST_FLUSH  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       mode_ff, mode_in;
   logic             priv_ff, priv_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic [IDX_W-1:0] sidx_ff, sidx_in;
   logic [1:0]       sub_ff, sub_in;
   logic [7:0]       byte_ff, byte_in;
   logic [7:0]       term_ff, term_in;

   logic             pend_valid_ff, pend_valid_in;
   logic [3:0]       pend_cmd_ff, pend_cmd_in;
   logic [15:0]      pend_a_ff, pend_a_in;
   logic [15:0]      pend_b_ff, pend_b_in;

   logic             out_valid_ff, out_valid_in;
   logic [3:0]       out_cmd_ff, out_cmd_in;
   logic [7:0]       out_term_ff, out_term_in;
   logic [15:0]      out_a_ff, out_a_in;
   logic [15:0]      out_b_ff, out_b_in;
   logic             out_last_ff, out_last_in;

   logic             out_free;
   logic             is_digit;
   logic             is_letter;
   logic [15:0]      move_n;
   logic [4:0]       pal;
   logic             sgr_emit;
   logic             sgr_done;
   logic [3:0]       sgr_cmd;
   logic [15:0]      sgr_a;

   assign out_free  = !out_valid_ff || out_ready;
   assign is_digit  = (byte_ff >= CH_ZERO) && (byte_ff <= CH_NINE);
   assign is_letter = ((byte_ff >= CH_UPPER_A) && (byte_ff <= CH_UPPER_Z)) ||
                      ((byte_ff >= CH_LOWER_A) && (byte_ff <= CH_LOWER_Z));
   assign move_n    = (p0 != '0) ? {1'b0, p0} : 16'd1;
   assign pal       = palette_of(store_rd);
   assign store_idx = (state_ff == ST_SGR) ? sidx_ff : pidx_ff;

   // Command produced by the current SGR parameter and sub-step.
   always_comb begin
      sgr_emit = 1'b1;
      sgr_done = 1'b1;
      sgr_cmd  = CMD_FG;
      sgr_a    = COLOR_FG_DEFAULT;
      if (store_rd == PV_SGR_RESET) begin
         case (sub_ff)
            2'd0: begin
               sgr_cmd  = CMD_REVERSE;
               sgr_a    = 16'd0;
               sgr_done = 1'b0;
            end
            2'd1: begin
               sgr_cmd  = CMD_FG;
               sgr_a    = COLOR_FG_DEFAULT;
               sgr_done = 1'b0;
            end
            default: begin
               sgr_cmd = CMD_BG;
               sgr_a   = COLOR_BG_DEFAULT;
            end
         endcase
      end else if (store_rd == PV_SGR_REVERSE) begin
         sgr_cmd = CMD_REVERSE;
         sgr_a   = 16'd1;
      end else if (store_rd == PV_SGR_FG_DEFAULT) begin
         sgr_cmd = CMD_FG;
         sgr_a   = COLOR_FG_DEFAULT;
      end else if (pal[4]) begin
         sgr_cmd = CMD_FG;
         sgr_a   = {12'd0, pal[3:0]};
      end else begin
         sgr_emit = 1'b0;
      end
   end

   // Sequencer: one byte at a time, commands staged through a holding
   // register so that the last one can be marked once it is known.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      priv_in       = priv_ff;
      pidx_in       = pidx_ff;
      sidx_in       = sidx_ff;
      sub_in        = sub_ff;
      byte_in       = byte_ff;
      term_in       = term_ff;
      pend_valid_in = pend_valid_ff;
      pend_cmd_in   = pend_cmd_ff;
      pend_a_in     = pend_a_ff;
      pend_b_in     = pend_b_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      out_cmd_in    = out_cmd_ff;
      out_term_in   = out_term_ff;
      out_a_in      = out_a_ff;
      out_b_in      = out_b_ff;
      out_last_in   = out_last_ff;
      store_ctl     = '0;
      in_ready      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               byte_in  = in_byte;
               term_in  = in_terminal;
               state_in = ST_DECODE;
               if (in_first) begin
                  mode_in         = MODE_NORMAL;
                  priv_in         = 1'b0;
                  pidx_in         = '0;
                  store_ctl.clear = 1'b1;
               end
            end
         end

         ST_DECODE: begin
            state_in = ST_IDLE;
            if (display_en) begin
               unique case (mode_ff)
                  MODE_NORMAL: begin
                     if (byte_ff == CH_ESC) begin
                        mode_in = MODE_ESC;
                     end else begin
                        pend_valid_in = 1'b1;
                        pend_cmd_in   = CMD_PUTC;
                        pend_a_in     = {8'd0, byte_ff};
                        pend_b_in     = 16'd0;
                        state_in      = ST_FLUSH;
                     end
                  end
                  MODE_ESC: begin
                     if (byte_ff == CH_LBRACK) begin
                        mode_in         = MODE_CSI;
                        priv_in         = 1'b0;
                        pidx_in         = '0;
                        store_ctl.clear = 1'b1;
                     end else begin
                        mode_in       = MODE_NORMAL;
                        pend_valid_in = 1'b1;
                        pend_cmd_in   = CMD_PUTC;
                        pend_a_in     = {8'd0, CH_ESC};
                        pend_b_in     = 16'd0;
                        state_in      = ST_ESC2;
                     end
                  end
                  MODE_CSI: begin
                     if (byte_ff == CH_QMARK) begin
                        priv_in = 1'b1;
                     end else if (is_digit) begin
                        store_ctl.acc   = 1'b1;
                        store_ctl.digit = 4'(byte_ff - CH_ZERO);
                     end else if (byte_ff == CH_SEMI) begin
                        if (pidx_ff != IDX_LAST) begin
                           pidx_in = pidx_ff + IDX_W'(1);
                        end
                     end else if (is_letter) begin
                        mode_in   = MODE_NORMAL;
                        pend_a_in = 16'd0;
                        pend_b_in = 16'd0;
                        if (priv_ff) begin
                           if (p0 == PV_CURSOR &&
                               (byte_ff == FIN_SET || byte_ff == FIN_RESET)) begin
                              pend_valid_in = 1'b1;
                              pend_cmd_in   = CMD_CURSOR;
                              pend_a_in     = {15'd0, byte_ff == FIN_SET};
                              state_in      = ST_FLUSH;
                           end
                        end else begin
                           unique case (byte_ff) inside
                              FIN_CUP_H, FIN_CUP_F: begin
                                 pend_valid_in = 1'b1;
                                 pend_cmd_in   = CMD_SETPOS;
                                 pend_a_in     = (p1 != '0) ? ({1'b0, p1} - 16'd1) : 16'd0;
                                 pend_b_in     = (p0 != '0) ? ({1'b0, p0} - 16'd1) : 16'd0;
                                 state_in      = ST_FLUSH;
                              end
                              FIN_CUU: begin
                                 pend_valid_in = 1'b1;
                                 pend_cmd_in   = CMD_MOVE;
                                 pend_b_in     = 16'd0 - move_n;
                                 state_in      = ST_FLUSH;
                              end
                              FIN_CUD: begin
                                 pend_valid_in = 1'b1;
                                 pend_cmd_in   = CMD_MOVE;
                                 pend_b_in     = move_n;
                                 state_in      = ST_FLUSH;
                              end
                              FIN_CUF: begin
                                 pend_valid_in = 1'b1;
                                 pend_cmd_in   = CMD_MOVE;
                                 pend_a_in     = move_n;
                                 state_in      = ST_FLUSH;
                              end
                              FIN_CUB: begin
                                 pend_valid_in = 1'b1;
                                 pend_cmd_in   = CMD_MOVE;
                                 pend_a_in     = 16'd0 - move_n;
                                 state_in      = ST_FLUSH;
                              end
                              FIN_ED: begin
                                 pend_valid_in = 1'b1;
                                 pend_cmd_in   = (p0 == PV_ERASE_ALL) ? CMD_CLRSCR : CMD_CLREOS;
                                 state_in      = ST_FLUSH;
                              end
                              FIN_EL: begin
                                 pend_valid_in = 1'b1;
                                 pend_cmd_in   = (p0 == PV_ERASE_ALL) ? CMD_CLRLINE : CMD_CLREOL;
                                 state_in      = ST_FLUSH;
                              end
                              FIN_SGR: begin
                                 sidx_in  = '0;
                                 sub_in   = 2'd0;
                                 state_in = ST_SGR;
                              end
                              default: begin
                                 state_in = ST_IDLE;
                              end
                           endcase
                        end
                     end else if (byte_ff == CH_ESC) begin
                        mode_in = MODE_ESC;
                     end
                  end
                  default: begin
                     mode_in = MODE_NORMAL;
                  end
               endcase
            end
         end

         // Second character of an escape that did not open a sequence.
         ST_ESC2: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_cmd_in   = pend_cmd_ff;
               out_term_in  = term_ff;
               out_a_in     = pend_a_ff;
               out_b_in     = pend_b_ff;
               out_last_in  = 1'b0;
               pend_cmd_in  = CMD_PUTC;
               pend_a_in    = {8'd0, byte_ff};
               pend_b_in    = 16'd0;
               state_in     = ST_FLUSH;
            end
         end

         // SGR walk, one step per cycle unless the output is full.
         ST_SGR: begin
            if (!(sgr_emit && pend_valid_ff && !out_free)) begin
               if (sgr_emit) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_cmd_in   = pend_cmd_ff;
                     out_term_in  = term_ff;
                     out_a_in     = pend_a_ff;
                     out_b_in     = pend_b_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_cmd_in   = sgr_cmd;
                  pend_a_in     = sgr_a;
                  pend_b_in     = 16'd0;
               end
               if (sgr_done) begin
                  sub_in = 2'd0;
                  if (sidx_ff == pidx_ff) begin
                     state_in = ST_FLUSH;
                  end else begin
                     sidx_in = sidx_ff + IDX_W'(1);
                  end
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end
         end

         // Hand over the held command as the last one of this byte.
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_cmd_in    = pend_cmd_ff;
               out_term_in   = term_ff;
               out_a_in      = pend_a_ff;
               out_b_in      = pend_b_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_NORMAL;
         priv_ff       <= 1'b0;
         pidx_ff       <= '0;
         sidx_ff       <= '0;
         sub_ff        <= 2'd0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         priv_ff       <= priv_in;
         pidx_ff       <= pidx_in;
         sidx_ff       <= sidx_in;
         sub_ff        <= sub_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      term_ff     <= term_in;
      pend_cmd_ff <= pend_cmd_in;
      pend_a_ff   <= pend_a_in;
      pend_b_ff   <= pend_b_in;
      out_cmd_ff  <= out_cmd_in;
      out_term_ff <= out_term_in;
      out_a_ff    <= out_a_in;
      out_b_ff    <= out_b_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid    = out_valid_ff;
   assign out_cmd      = out_cmd_ff;
   assign out_terminal = out_term_ff;
   assign out_a        = out_a_ff;
   assign out_b        = out_b_ff;
   assign out_last     = out_last_ff;

endmodule

>>> rtl/core/ansi_csi_escape_decoder_core.sv
// Terminal escape decoder: each request transaction carries one output byte
// and is turned into zero or more display commands on the response channel,
// the final one of each byte marked by tlast. The block handles one byte at a
// time: a plain character is accepted, decoded and handed over to the output
// register; for a byte that follows a lone escape the escape itself is handed
// over first; a byte that only changes parser state is accepted and decoded;
// and an SGR final is followed by a walk with one step per SGR parameter and
// one per extra command of a reset parameter. The steps are set by the byte
// sequencer and by the parameter store's single read port, which feeds its
// multiply-add unit and which both digit accumulation and the SGR walk use. A
// finished command waits in the output register while the next byte is taken,
// and a full output register stalls only the cycle that has a further command
// to hand over. Clearing the display_enabled register at address 0 makes bytes
// produce no commands and leaves the parser as it is, except that a
// start-of-write flag still resets it.
module ansi_csi_escape_decoder_core
   import acsi_pkg::*;
#(
   parameter int MAX_PARAMS = ACSI_MAX_PARAMS
) (
   input  logic        clock,
   input  logic        reset,
   // Request: tdata = char_byte[7:0], terminal[15:8]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // Request: tuser = first_of_write[0]
   input  logic        req_tuser,
   // Response: tdata = terminal_out[7:0], arg_a[23:8], arg_b[39:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // Response: tuser = command[3:0]
   output logic [3:0]  rsp_tuser,
   output logic        rsp_tlast,
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

   logic               display_en_ff;
   logic               csr_write;
   acsi_store_ctl_type store_ctl;
   logic [IDX_W-1:0]   store_idx;
   logic [PARAM_W-1:0] store_rd;
   logic [PARAM_W-1:0] p0;
   logic [PARAM_W-1:0] p1;
   logic [3:0]         cmd;
   logic [7:0]         term_out;
   logic [15:0]        arg_a;
   logic [15:0]        arg_b;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         display_en_ff <= 1'b1;
      end else if (csr_write && csr_paddr[2] == CSR_IDX_DISPLAY_EN) begin
         display_en_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_DISPLAY_EN) ? {31'd0, display_en_ff} : 32'd0;

   acsi_param_store #(
      .MAX_PARAMS (MAX_PARAMS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (store_ctl),
      .idx      (store_idx),
      .rd_value (store_rd),
      .p0       (p0),
      .p1       (p1)
   );

   acsi_sequencer #(
      .MAX_PARAMS (MAX_PARAMS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .display_en   (display_en_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_byte      (req_tdata[7:0]),
      .in_terminal  (req_tdata[15:8]),
      .in_first     (req_tuser),
      .store_ctl    (store_ctl),
      .store_idx    (store_idx),
      .store_rd     (store_rd),
      .p0           (p0),
      .p1           (p1),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_cmd      (cmd),
      .out_terminal (term_out),
      .out_a        (arg_a),
      .out_b        (arg_b),
      .out_last     (rsp_tlast)
   );

   // Response packing.
   assign rsp_tdata = {arg_b, arg_a, term_out};
   assign rsp_tuser = cmd;

endmodule

>>> tb/ansi_csi_escape_decoder_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and register port of the escape decoder.
// It keeps its own copy of the parser, turns every accepted request
// transaction into the display commands it should cause, and compares each
// response transaction with the oldest command still outstanding.
module ansi_csi_escape_decoder_checker
   import acsi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [3:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int unsigned error_count,
   output int unsigned pending
);

   localparam logic [2:0] EN_ADDR = {CSR_IDX_DISPLAY_EN, 2'b00};

   typedef struct packed {
      logic [3:0]  cmd;
      logic [7:0]  term;
      logic [15:0] arg_a;
      logic [15:0] arg_b;
      logic        last;
   } display_cmd_type;

   // Shadow copy of the register and the parser.
   logic        enabled;
   logic [1:0]  mode;
   logic        private_seq;
   logic [1:0]  slot;
   logic [14:0] slot_value [ACSI_MAX_PARAMS];
   logic        slot_used [ACSI_MAX_PARAMS];

   display_cmd_type pending_cmds[$];
   logic [7:0]      cur_term;
   int unsigned     batch_len;
   int unsigned     fail_total;

   function bit count_failure();
      fail_total++;
      return fail_total <= 10;
   endfunction

   task clear_sequence();
      private_seq = 1'b0;
      slot = '0;
      for (int i = 0; i < ACSI_MAX_PARAMS; i++) begin
         slot_value[i] = '0;
         slot_used[i] = 1'b0;
      end
   endtask

   // An absent parameter reads as zero.
   function int param_of(int i);
      if (i >= ACSI_MAX_PARAMS || !slot_used[i])
         return 0;
      return int'(slot_value[i]);
   endfunction

   // VGA palette index for an SGR foreground code, or -1 if it names none.
   function int sgr_color(int p);
      case (p)
         30: return 0;
         31: return 4;
         32: return 2;
         33: return 14;
         34: return 1;
         35: return 5;
         36: return 3;
         37: return 7;
         90: return 8;
         91: return 12;
         92: return 10;
         93: return 14;
         94: return 9;
         95: return 13;
         96: return 11;
         97: return 15;
         default: return -1;
      endcase
   endfunction

   task push_cmd(input logic [3:0] code, input int a, input int b);
      display_cmd_type e;
      e.cmd = code;
      e.term = cur_term;
      e.arg_a = a[15:0];
      e.arg_b = b[15:0];
      e.last = 1'b0;
      pending_cmds.push_back(e);
      batch_len++;
   endtask

   // Applies a letter final to the collected sequence.
   task apply_final(input logic [7:0] fin);
      int p0;
      int p1;
      int n;
      int p;
      int c;
      p0 = param_of(0);
      p1 = (slot >= 2'd1) ? param_of(1) : 0;
      n = (p0 > 0) ? p0 : 1;
      if (private_seq) begin
         // Only the cursor show and hide pair is honored in private mode.
         if (p0 == int'(PV_CURSOR) && (fin == FIN_SET || fin == FIN_RESET))
            push_cmd(CMD_CURSOR, (fin == FIN_SET) ? 1 : 0, 0);
      end else begin
         case (fin) inside
            FIN_CUP_H, FIN_CUP_F: push_cmd(CMD_SETPOS, (p1 > 0) ? p1 - 1 : 0,
                                           (p0 > 0) ? p0 - 1 : 0);
            FIN_CUU: push_cmd(CMD_MOVE, 0, -n);
            FIN_CUD: push_cmd(CMD_MOVE, 0, n);
            FIN_CUF: push_cmd(CMD_MOVE, n, 0);
            FIN_CUB: push_cmd(CMD_MOVE, -n, 0);
            FIN_ED: push_cmd((p0 == int'(PV_ERASE_ALL)) ? CMD_CLRSCR : CMD_CLREOS, 0, 0);
            FIN_EL: push_cmd((p0 == int'(PV_ERASE_ALL)) ? CMD_CLRLINE : CMD_CLREOL, 0, 0);
            FIN_SGR: begin
               // Every collected parameter is walked in order.
               for (int i = 0; i <= int'(slot); i++) begin
                  p = param_of(i);
                  if (p == int'(PV_SGR_RESET)) begin
                     push_cmd(CMD_REVERSE, 0, 0);
                     push_cmd(CMD_FG, int'(COLOR_FG_DEFAULT), 0);
                     push_cmd(CMD_BG, int'(COLOR_BG_DEFAULT), 0);
                  end else if (p == int'(PV_SGR_REVERSE)) begin
                     push_cmd(CMD_REVERSE, 1, 0);
                  end else if (p == int'(PV_SGR_FG_DEFAULT)) begin
                     push_cmd(CMD_FG, int'(COLOR_FG_DEFAULT), 0);
                  end else begin
                     c = sgr_color(p);
                     if (c >= 0)
                        push_cmd(CMD_FG, c, 0);
                  end
               end
            end
            default: ;
         endcase
      end
   endtask

   // Advances the parser by one byte and queues the commands it causes.
   task decode_byte(input logic [7:0] ch, input logic [7:0] term, input logic first);
      display_cmd_type tail;
      int v;
      cur_term = term;
      batch_len = 0;
      if (first) begin
         mode = MODE_NORMAL;
         clear_sequence();
      end
      if (enabled) begin
         case (mode)
            MODE_ESC: begin
               if (ch == CH_LBRACK) begin
                  mode = MODE_CSI;
                  clear_sequence();
               end else begin
                  push_cmd(CMD_PUTC, int'(CH_ESC), 0);
                  push_cmd(CMD_PUTC, int'(ch), 0);
                  mode = MODE_NORMAL;
               end
            end
            MODE_CSI: begin
               if (ch == CH_QMARK) begin
                  private_seq = 1'b1;
               end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
                  // Accumulate the digit, saturating at the cap.
                  v = slot_used[slot] ? int'(slot_value[slot]) : 0;
                  v = v * 10 + int'(ch - CH_ZERO);
                  if (v > int'(PARAM_CAP))
                     v = int'(PARAM_CAP);
                  slot_value[slot] = v[14:0];
                  slot_used[slot] = 1'b1;
               end else if (ch == CH_SEMI) begin
                  if (int'(slot) + 1 < ACSI_MAX_PARAMS)
                     slot = slot + 2'd1;
               end else if ((ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ||
                            (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)) begin
                  apply_final(ch);
                  mode = MODE_NORMAL;
               end else if (ch == CH_ESC) begin
                  mode = MODE_ESC;
               end
            end
            default: begin
               if (ch == CH_ESC)
                  mode = MODE_ESC;
               else
                  push_cmd(CMD_PUTC, int'(ch), 0);
            end
         endcase
      end
      // The final command of the byte carries the last flag.
      if (batch_len > 0) begin
         tail = pending_cmds[$];
         void'(pending_cmds.pop_back());
         tail.last = 1'b1;
         pending_cmds.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      display_cmd_type want;
      display_cmd_type got;
      if (reset) begin
         enabled = 1'b1;
         mode = MODE_NORMAL;
         clear_sequence();
         pending_cmds.delete();
         fail_total = 0;
      end else begin
         // Compare a response transaction with the oldest outstanding command.
         if (rsp_tvalid && rsp_tready) begin
            got.cmd = rsp_tuser;
            got.term = rsp_tdata[7:0];
            got.arg_a = rsp_tdata[23:8];
            got.arg_b = rsp_tdata[39:24];
            got.last = rsp_tlast;
            if (pending_cmds.size() == 0) begin
               if (count_failure())
                  $display("%0t: unexpected command cmd=%0d term=%0d a=%0d b=%0d last=%0d",
                           $realtime, got.cmd, got.term, $signed(got.arg_a),
                           $signed(got.arg_b), got.last);
            end else begin
               want = pending_cmds.pop_front();
               if (got !== want) begin
                  if (count_failure()) begin
                     $display("%0t: command mismatch: expected cmd=%0d term=%0d a=%0d b=%0d last=%0d",
                              $realtime, want.cmd, want.term, $signed(want.arg_a),
                              $signed(want.arg_b), want.last);
                     $display("%0t: command mismatch: got cmd=%0d term=%0d a=%0d b=%0d last=%0d",
                              $realtime, got.cmd, got.term, $signed(got.arg_a),
                              $signed(got.arg_b), got.last);
                  end
               end
            end
         end
         // Track register writes and check reads.
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == EN_ADDR)
                  enabled = csr_pwdata[0];
            end else if (csr_paddr == EN_ADDR && csr_prdata !== {31'b0, enabled}) begin
               if (count_failure())
                  $display("%0t: register read mismatch: expected %0h, got %0h",
                           $realtime, {31'b0, enabled}, csr_prdata);
            end
         end
         if (req_tvalid && req_tready)
            decode_byte(req_tdata[7:0], req_tdata[15:8], req_tuser);
      end
      error_count <= fail_total;
      pending <= pending_cmds.size();
   end

endmodule

>>> tb/tb_ansi_csi_escape_decoder_core.sv
`timescale 1ns / 1ps

// Drives terminal byte streams into the escape decoder: a few hand-picked
// sequences, then random well-formed and broken escape sequences under
// several idle and stall patterns, with the display switched off for a while
// in the middle. The checker beside the block does all the comparing.
module tb_ansi_csi_escape_decoder_core;
   import acsi_pkg::*;

   localparam logic [2:0] EN_ADDR = {CSR_IDX_DISPLAY_EN, 2'b00};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;     // char_byte[7:0], terminal[15:8]
   logic        req_tuser;     // first_of_write[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;     // terminal_out[7:0], arg_a[23:8], arg_b[39:24]
   logic [3:0]  rsp_tuser;     // command[3:0]
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int unsigned error_count;
   int unsigned pending;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned bytes_sent;
   logic [7:0]  cur_term;

   ansi_csi_escape_decoder_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ansi_csi_escape_decoder_checker cmd_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .error_count (error_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Upper bound on the whole run.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // The receiver stalls at random according to the current phase.
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // Sends one byte as a request transaction and returns at the accepting edge.
   task send_byte(input logic [7:0] ch, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {cur_term, ch};
      req_tuser <= first;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], 1'b0);
   endtask

   task send_csi(input string body);
      send_byte(CH_ESC, 1'b0);
      send_byte(CH_LBRACK, 1'b0);
      send_text(body);
   endtask

   task send_number(input int unsigned v, input bit lead_zero);
      logic [7:0] digits[$];
      do begin
         digits.push_front(CH_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      if (lead_zero)
         digits.push_front(CH_ZERO);
      foreach (digits[i])
         send_byte(digits[i], 1'b0);
   endtask

   // Parameter values that mean something to at least one final, plus noise.
   function int unsigned pick_param();
      case ($urandom_range(9))
         0: return 0;
         1: return 7;
         2: return 39;
         3: return 30 + $urandom_range(7);
         4: return 90 + $urandom_range(7);
         5: return 25;
         6: return $urandom_range(1, 3);
         7: return $urandom_range(99);
         8: return $urandom_range(32767);
         default: return $urandom_range(32768, 999999);
      endcase
   endfunction

   function logic [7:0] pick_final();
      case ($urandom_range(13)) inside
         0: return FIN_CUP_H;
         1: return FIN_CUP_F;
         2: return FIN_CUU;
         3: return FIN_CUD;
         4: return FIN_CUF;
         5: return FIN_CUB;
         6: return FIN_ED;
         7: return FIN_EL;
         [8:10]: return FIN_SGR;
         11: return FIN_SET;
         12: return FIN_RESET;
         default: begin
            if ($urandom_range(1))
               return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
            return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
         end
      endcase
   endfunction

   // One random chunk of terminal output: mostly escape sequences with
   // random content, some plain text, and some broken sequences.
   task send_random_sequence();
      int unsigned kind;
      int unsigned nparm;
      logic        first;
      if ($urandom_range(3) == 0)
         cur_term = 8'($urandom_range(255));
      first = ($urandom_range(15) == 0);
      kind = $urandom_range(99);
      if (kind < 15) begin
         // Plain bytes of any value.
         send_byte(8'($urandom_range(255)), first);
         repeat ($urandom_range(3))
            send_byte(8'($urandom_range(255)), 1'b0);
      end else if (kind < 25) begin
         // Escape followed by an arbitrary byte.
         send_byte(CH_ESC, first);
         send_byte(8'($urandom_range(255)), 1'b0);
      end else if (kind < 35) begin
         // Private sequences, mostly the cursor show and hide pair.
         send_csi("?");
         send_number(($urandom_range(4) != 0) ? 25 : pick_param(), 1'b0);
         if ($urandom_range(4) != 0)
            send_byte($urandom_range(1) ? FIN_SET : FIN_RESET, 1'b0);
         else
            send_byte(pick_final(), 1'b0);
      end else if (kind < 50) begin
         // Broken sequences.
         send_byte(CH_ESC, first);
         send_byte(CH_LBRACK, 1'b0);
         send_number(pick_param(), 1'b0);
         case ($urandom_range(3))
            0: begin
               send_byte(CH_ESC, 1'b0);
               send_byte(8'($urandom_range(255)), 1'b0);
            end
            1: begin
               send_byte($urandom_range(1) ? 8'h20 : 8'($urandom_range(128, 255)), 1'b0);
               send_byte(pick_final(), 1'b0);
            end
            2: send_byte(8'($urandom_range(255)), 1'b1);
            default: begin
               send_byte(CH_QMARK, 1'b0);
               send_byte(pick_final(), 1'b0);
            end
         endcase
      end else begin
         // Well-formed sequence with up to five parameters, some left empty.
         send_byte(CH_ESC, first);
         send_byte(CH_LBRACK, 1'b0);
         if ($urandom_range(9) == 0)
            send_byte(CH_QMARK, 1'b0);
         nparm = $urandom_range(5);
         for (int i = 0; i < nparm; i++) begin
            if (i > 0)
               send_byte(CH_SEMI, 1'b0);
            if ($urandom_range(6) != 0)
               send_number(pick_param(), $urandom_range(9) == 0);
         end
         send_byte(pick_final(), 1'b0);
      end
   endtask

   task send_random_bytes(input int unsigned count);
      int unsigned target;
      target = bytes_sent + count;
      while (bytes_sent < target)
         send_random_sequence();
   endtask

   // Stops sending and waits until every command has come out and the block
   // has had time to finish a byte that causes none.
   task drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task csr_access(input logic write, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= EN_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task set_display(input logic on);
      csr_access(1'b1, {31'($urandom), on});
      csr_access(1'b0, '0);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      bytes_sent = 0;
      cur_term = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_display(1'b1);

      // Directed part: field extremes and the special cases of the parser.
      send_byte(8'h00, 1'b1);
      cur_term = 8'hff;
      send_byte(8'hff, 1'b0);
      cur_term = 8'h5a;
      send_byte(CH_ESC, 1'b0);
      send_byte("x", 1'b0);
      // Saturated parameter drives the largest move.
      send_csi("99999A");
      // Four empty parameters each reset the attributes; the extra ';' is dropped.
      send_csi(";;;;m");
      // An escape inside a sequence starts a new one.
      send_csi("3");
      send_byte(CH_ESC, 1'b0);
      send_text("[2J");
      // The start of a write throws away a half-built sequence.
      send_csi("3");
      send_byte("m", 1'b1);

      // Random part, first with no idling and then with an idle sender.
      send_random_bytes(35);
      send_idle_pct = 86;
      send_random_bytes(35);

      // Switch the display off mid-sequence; the parser must resume afterward.
      send_idle_pct = 0;
      drain();
      send_csi("3");
      drain();
      set_display(1'b0);
      send_random_bytes(20);
      drain();
      set_display(1'b1);
      send_text("1m");

      // Stalling receiver, then both sides idling now and then.
      stall_pct = 86;
      send_random_bytes(35);
      send_idle_pct = 16;
      stall_pct = 16;
      send_random_bytes(35);

      drain();
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/core/acsi_pkg.sv
rtl/core/acsi_param_store.sv
rtl/core/acsi_sequencer.sv
rtl/core/ansi_csi_escape_decoder_core.sv
tb/ansi_csi_escape_decoder_checker.sv
tb/tb_ansi_csi_escape_decoder_core.sv
